FILE: hw/rtl/pdpc_pkg.sv
// shared types and constants of the dual motor pd position control unit
`default_nettype none

package pdpc_pkg;

   // field widths
   localparam int POS_W      = 21;
   localparam int DIFF_W     = POS_W + 1;
   localparam int TIME_W     = 13;
   localparam int PTIME_W    = TIME_W + 1;
   localparam int GAIN_W     = 16;
   localparam int SPEED_W    = 7;
   localparam int DRIVE_W    = SPEED_W + 1;
   localparam int DVS_W      = 13;
   localparam int PROD_W     = DIFF_W + GAIN_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int FRAC_W     = 8;
   localparam int DQ_W       = SUM_W - FRAC_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = POS_W;

   // divider sequencing
   localparam int DIV_STEPS  = POS_W;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   // control constants
   localparam int DONE_MS    = 5000;
   localparam int TOLERANCE  = 5;
   localparam int MIN_DRIVE  = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_TARGET     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_TARGET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_MAX_SPEED  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_MAX_SPEED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_KP         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_KD         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_KP        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_KD        = 3'd7;

   typedef struct packed {
      logic signed [POS_W-1:0]  left_target;
      logic signed [POS_W-1:0]  right_target;
      logic [SPEED_W-1:0]       left_max_speed;
      logic [SPEED_W-1:0]       right_max_speed;
      logic signed [GAIN_W-1:0] left_kp;
      logic signed [GAIN_W-1:0] left_kd;
      logic signed [GAIN_W-1:0] right_kp;
      logic signed [GAIN_W-1:0] right_kd;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      left_target:     '0,
      right_target:    '0,
      left_max_speed:  7'd100,
      right_max_speed: 7'd100,
      left_kp:         '0,
      left_kd:         '0,
      right_kp:        '0,
      right_kd:        '0
   };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PREP,
      ST_DIV,
      ST_MUL_P,
      ST_MUL_D,
      ST_ADD,
      ST_LIMIT,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic check;
      logic prep;
      logic div_step;
      logic mul_p;
      logic mul_d;
      logic add;
      logic limit;
      logic commit;
      logic sel;       // 0 left motor, 1 right motor
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic done_hit;
   } status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/pdpc_regs.sv
// configuration register file of the pd position control unit
`default_nettype none

module pdpc_regs import pdpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_LEFT_TARGET:     cfg_in.left_target     = csr_wdata[POS_W-1:0];
            REG_RIGHT_TARGET:    cfg_in.right_target    = csr_wdata[POS_W-1:0];
            REG_LEFT_MAX_SPEED:  cfg_in.left_max_speed  = csr_wdata[SPEED_W-1:0];
            REG_RIGHT_MAX_SPEED: cfg_in.right_max_speed = csr_wdata[SPEED_W-1:0];
            REG_LEFT_KP:         cfg_in.left_kp         = csr_wdata[GAIN_W-1:0];
            REG_LEFT_KD:         cfg_in.left_kd         = csr_wdata[GAIN_W-1:0];
            REG_RIGHT_KP:        cfg_in.right_kp        = csr_wdata[GAIN_W-1:0];
            REG_RIGHT_KD:        cfg_in.right_kd        = csr_wdata[GAIN_W-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/pdpc_ctrl.sv
// sequencing state machine of the pd position control unit
`default_nettype none

module pdpc_ctrl import pdpc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type        state_ff, state_in;
   logic             sel_ff, sel_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      req_tready   = 1'b0;
      cmd          = '0;
      cmd.sel      = sel_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            sel_in    = 1'b0;
            state_in  = status.done_hit ? ST_OUT : ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.mul_p = 1'b1;
            state_in  = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_d = 1'b1;
            state_in  = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_LIMIT;
         end
         ST_LIMIT: begin
            cmd.limit = 1'b1;
            if (sel_ff) begin
               state_in = ST_OUT;
            end else begin
               sel_in   = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/pdpc_datapath.sv
// arithmetic datapath: done test, serial divider, shared multiplier, drive limiter
`default_nettype none

module pdpc_datapath import pdpc_pkg::*; #(
   parameter int LEFT_ACCEL_Q4  = 16,
   parameter int RIGHT_ACCEL_Q4 = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  cfg_type            cfg,
   input  logic [POS_W-1:0]   in_left_position,
   input  logic [POS_W-1:0]   in_right_position,
   input  logic [TIME_W-1:0]  in_elapsed_ms,
   output status_type         status,
   output logic [DRIVE_W-1:0] out_left_drive,
   output logic [DRIVE_W-1:0] out_right_drive,
   output logic               out_move_done
);

   localparam int ACCEL_MAX = (LEFT_ACCEL_Q4 > RIGHT_ACCEL_Q4) ? LEFT_ACCEL_Q4 : RIGHT_ACCEL_Q4;
   localparam int ACC_W     = $clog2(ACCEL_MAX + 1);
   localparam int RAMP_W    = ACC_W + TIME_W;

   function automatic logic in_tol(input logic signed [POS_W-1:0] pos,
                                   input logic signed [POS_W-1:0] tgt);
      logic [POS_W-1:0]    a;
      logic [POS_W-1:0]    b;
      logic signed [POS_W:0] d;
      a = pos[POS_W-1] ? POS_W'(-pos) : pos;
      b = tgt[POS_W-1] ? POS_W'(-tgt) : tgt;
      d = $signed({1'b0, a}) - $signed({1'b0, b});
      return (d < TOLERANCE) && (d > -TOLERANCE);
   endfunction

   // captured item and carried state
   logic signed [POS_W-1:0]   lpos_ff, rpos_ff;
   logic [TIME_W-1:0]         t_ff;
   logic signed [PTIME_W-1:0] ptime_ff;
   logic signed [POS_W-1:0]   lprev_ff, rprev_ff;
   logic                      done_ff;

   // divider
   logic [POS_W-1:0] dvd_ff;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dsr_ff;
   logic             rneg_ff, dzero_ff;
   logic [DVS_W:0]   trial;
   logic             fits;

   // multiply and accumulate
   logic [RAMP_W-1:0]        ramp_ff;
   logic signed [PROD_W-1:0] prod_ff, acc_ff, prod_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;

   logic [DRIVE_W-1:0] ldrive_ff, rdrive_ff;
   logic [DRIVE_W-1:0] odl_ff, odr_ff;
   logic               odone_ff;

   // motor select
   logic signed [POS_W-1:0]  pos_sel, prev_sel, tgt_sel;
   logic [SPEED_W-1:0]       maxs_sel;
   logic signed [GAIN_W-1:0] kp_sel, kd_sel;
   logic [ACC_W-1:0]         accel_sel;

   logic                      done_now;
   logic signed [PTIME_W:0]   dt;
   logic [PTIME_W:0]          dt_mag;
   logic signed [DIFF_W-1:0]  diff, err, rate, mul_a;
   logic [DIFF_W-1:0]         diff_mag;
   logic signed [GAIN_W-1:0]  mul_b;

   // limiter
   logic signed [SUM_W-1:0] sbias;
   logic signed [DQ_W-1:0]  dq;
   logic                    dneg;
   logic [DQ_W-1:0]         dmag;
   logic [SPEED_W-1:0]      m1, m2, m3;
   logic [RAMP_W-1:0]       rlim;
   logic [DRIVE_W-1:0]      drv;

   always_comb begin
      pos_sel   = cmd.sel ? rpos_ff : lpos_ff;
      prev_sel  = cmd.sel ? rprev_ff : lprev_ff;
      tgt_sel   = cmd.sel ? cfg.right_target : cfg.left_target;
      maxs_sel  = cmd.sel ? cfg.right_max_speed : cfg.left_max_speed;
      kp_sel    = cmd.sel ? cfg.right_kp : cfg.left_kp;
      kd_sel    = cmd.sel ? cfg.right_kd : cfg.left_kd;
      accel_sel = cmd.sel ? ACC_W'(RIGHT_ACCEL_Q4) : ACC_W'(LEFT_ACCEL_Q4);
   end

   // move finished: timeout or both motors with a position magnitude near their target magnitude
   assign done_now = (t_ff >= TIME_W'(DONE_MS)) ||
                     (in_tol(lpos_ff, cfg.left_target) && in_tol(rpos_ff, cfg.right_target));
   assign status.done_hit = done_now;

   always_comb begin
      dt       = $signed({2'b00, t_ff}) - $signed({ptime_ff[PTIME_W-1], ptime_ff});
      dt_mag   = dt[PTIME_W] ? (PTIME_W+1)'(-dt) : dt;
      diff     = $signed({pos_sel[POS_W-1], pos_sel}) - $signed({prev_sel[POS_W-1], prev_sel});
      diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
      err      = $signed({pos_sel[POS_W-1], pos_sel}) - $signed({tgt_sel[POS_W-1], tgt_sel});
   end

   // restoring divider step, one quotient bit a cycle
   always_comb begin
      trial  = {rem_ff, dvd_ff[POS_W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      rem_in = fits ? DVS_W'(trial - {1'b0, dsr_ff}) : trial[DVS_W-1:0];
   end

   always_comb begin
      if (dzero_ff) begin
         rate = '0;
      end else if (rneg_ff) begin
         rate = -$signed({1'b0, dvd_ff});
      end else begin
         rate = $signed({1'b0, dvd_ff});
      end
      mul_a   = cmd.mul_d ? rate : err;
      mul_b   = cmd.mul_d ? kd_sel : kp_sel;
      prod_in = mul_a * mul_b;
      sum_in  = $signed({acc_ff[PROD_W-1], acc_ff}) + $signed({prod_ff[PROD_W-1], prod_ff});
   end

   // drive limiter: truncate q31.8 toward zero, clamp to speed and ramp, raise small drives
   always_comb begin
      sbias = sum_ff + SUM_W'(sum_ff[SUM_W-1] ? 255 : 0);
      dq    = sbias[SUM_W-1:FRAC_W];
      dneg  = dq[DQ_W-1];
      dmag  = dneg ? DQ_W'(-dq) : dq;
      m1    = (dmag > DQ_W'(maxs_sel)) ? maxs_sel : dmag[SPEED_W-1:0];
      rlim  = ramp_ff >> 4;
      m2    = (RAMP_W'(m1) > rlim) ? rlim[SPEED_W-1:0] : m1;
      m3    = ((tgt_sel != '0) && (maxs_sel != '0) && (m2 != '0) &&
               (m2 < SPEED_W'(MIN_DRIVE))) ? SPEED_W'(MIN_DRIVE) : m2;
      drv   = dneg ? DRIVE_W'(-{1'b0, m3}) : {1'b0, m3};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptime_ff <= '1;
         lprev_ff <= '0;
         rprev_ff <= '0;
      end else if (cmd.commit && !done_ff) begin
         ptime_ff <= $signed({1'b0, t_ff});
         lprev_ff <= lpos_ff;
         rprev_ff <= rpos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lpos_ff <= in_left_position;
         rpos_ff <= in_right_position;
         t_ff    <= in_elapsed_ms;
      end
      if (cmd.check) begin
         done_ff <= done_now;
      end
      if (cmd.prep) begin
         dvd_ff   <= diff_mag[POS_W-1:0];
         rem_ff   <= '0;
         dsr_ff   <= dt_mag[DVS_W-1:0];
         rneg_ff  <= diff[DIFF_W-1] ^ dt[PTIME_W];
         dzero_ff <= (dt == '0);
         ramp_ff  <= RAMP_W'(accel_sel) * RAMP_W'(t_ff);
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[POS_W-2:0], fits};
      end
      if (cmd.mul_p) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_d) begin
         acc_ff  <= prod_ff;
         prod_ff <= prod_in;
      end
      if (cmd.add) begin
         sum_ff <= sum_in;
      end
      if (cmd.limit) begin
         if (cmd.sel) begin
            rdrive_ff <= drv;
         end else begin
            ldrive_ff <= drv;
         end
      end
      if (cmd.commit) begin
         odl_ff   <= done_ff ? '0 : ldrive_ff;
         odr_ff   <= done_ff ? '0 : rdrive_ff;
         odone_ff <= done_ff;
      end
   end

   assign out_left_drive  = odl_ff;
   assign out_right_drive = odr_ff;
   assign out_move_done   = odone_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/dual_motor_pd_position_control_unit.sv
// top level of the dual motor pd position control unit
//
// channel    direction  handshake              payload
// req        in         req_tvalid/req_tready  both encoder positions, elapsed ms
// rsp        out        rsp_tvalid/rsp_tready  both drive commands, move done flag
// csr        in         csr_wr_en              register index and write data
//
// a move tick runs from the accept through the check state, then per motor the prep
// state, the bit-serial divider of the position change by the time step, both
// multiplies, the add and the limit, and a final state to load the output register
// a done tick (timeout or both in tolerance) goes from the check to the output state
// reset is synchronous; the unit comes up idle with no result pending
// a result waiting on rsp does not block the next item; a second result waits
// in the output stage until the first is taken
`default_nettype none

module dual_motor_pd_position_control_unit import pdpc_pkg::*; #(
   parameter int LEFT_ACCEL_Q4  = 16,
   parameter int RIGHT_ACCEL_Q4 = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // input item
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [55:0]           req_tdata,   // left_position, right_position, elapsed_ms
   // result item
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // left_drive, right_drive
   output logic                  rsp_tuser,   // move_done
   // configuration writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type            cfg;
   cmd_type            cmd;
   status_type         status;
   logic [DRIVE_W-1:0] left_drive, right_drive;

   // configuration registers; the user must write them only while the unit is idle, the block does not enforce it
   pdpc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: owns both handshakes and the output valid
   pdpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: one divider and one multiplier shared by both motors
   pdpc_datapath #(
      .LEFT_ACCEL_Q4  (LEFT_ACCEL_Q4),
      .RIGHT_ACCEL_Q4 (RIGHT_ACCEL_Q4)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cfg               (cfg),
      .in_left_position  (req_tdata[20:0]),
      .in_right_position (req_tdata[41:21]),
      .in_elapsed_ms     (req_tdata[54:42]),
      .status            (status),
      .out_left_drive    (left_drive),
      .out_right_drive   (right_drive),
      .out_move_done     (rsp_tuser)
   );

   // left drive in the low byte
   assign rsp_tdata = {right_drive, left_drive};

endmodule

`default_nettype wire

FILE: hw/rtl/pdpc_checker.sv
// port-level assertions of the pd position control unit and their bind
`default_nettype none

module pdpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // a finished move drives both motors to zero
   a_done_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 16'h0000)
      else $error("nonzero drive on a done result");

   // an accepted item keeps the unit busy for at least the check cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready right after accept");

   // reset leaves the unit idle with nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

endmodule

bind dual_motor_pd_position_control_unit pdpc_checker u_pdpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
